// ----- rtl/core/bbd_pkg.sv -----
`default_nettype none

package bbd_pkg;

  localparam int PIX_W       = 8;
  localparam int CFG_W       = 12;
  localparam int ROW_W       = 12;
  localparam int GAIN_W      = 12;
  localparam int PAT_W       = 2;
  localparam int SUM_W       = 10;
  localparam int PROD_W      = GAIN_W + SUM_W;
  localparam int APB_DATA_W  = 32;
  localparam int PADDR_W     = 5;
  localparam int OFIFO_DEPTH = 8;

  localparam int DEF_MAX_LINE_WIDTH = 2048;

  localparam logic [CFG_W-1:0]  RST_LINE_WIDTH   = 12'd640;
  localparam logic [CFG_W-1:0]  RST_FRAME_HEIGHT = 12'd480;
  localparam logic [PAT_W-1:0]  RST_PATTERN      = 2'd0;
  localparam logic [GAIN_W-1:0] RST_GAIN         = 12'd256;

  typedef enum logic [2:0] {
    REG_LINE_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_PATTERN      = 3'd2,
    REG_BLUE_GAIN    = 3'd3,
    REG_GREEN_GAIN   = 3'd4,
    REG_RED_GAIN     = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    AVG_COPY,
    AVG_TWO,
    AVG_FOUR
  } avg_e;

  typedef struct packed {
    logic [CFG_W-1:0]  line_width;
    logic [CFG_W-1:0]  frame_height;
    logic [PAT_W-1:0]  bayer_pattern;
    logic [GAIN_W-1:0] blue_gain;
    logic [GAIN_W-1:0] green_gain;
    logic [GAIN_W-1:0] red_gain;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    avg_e             mode;
  } chan_t;

  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
    logic  row_end;
    logic  frame_end;
  } px_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             row_end;
    logic             frame_end;
  } rgb_t;

endpackage

`default_nettype wire

// ----- rtl/core/bayer_bilinear_demosaic_wb.sv -----
// Bilinear Bayer demosaic with per-channel white balance.
// s_axis takes one raw 8-bit sample per request in raster order; tuser[0]
// marks the first sample of a frame and restarts the row and column counters.
// m_axis gives one B,G,R pixel for every interior position, emitted once the
// sample below and right of it has arrived; tlast marks the last interior
// pixel of a row, tuser[0] the last one of the frame. The outer one-pixel
// border yields no output.
// Throughput is one sample per cycle while s_axis_tready stays high. An accepted
// sample passes through the line store read with window and neighbor sums, the
// gain multiply, and round/clip into the output queue on its way to m_axis.
// The output queue holds 8 pixels; s_axis_tready drops only when queued plus
// in-flight pixels reach that depth, so a stalled receiver back-pressures
// the source after the queue fills and no pixel is lost.
// Registers (APB, byte address 4*i): line_width, frame_height, bayer_pattern,
// blue_gain, green_gain, red_gain (4.8 fixed point). Write them between frames.
// Reset clears counters, the window and the queue and loads the register
// defaults; the line stores need no clearing pass, since the first two lines of
// a frame produce no output.
`default_nettype none

module bayer_bilinear_demosaic_wb #(
  parameter int MAX_LINE_WIDTH = bbd_pkg::DEF_MAX_LINE_WIDTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // slave stream: tdata = raw_pixel[7:0]; tuser = frame_start[0]
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,
  input  wire logic [0:0]                     s_axis_tuser,
  // master stream: tdata = blue_out[7:0], green_out[15:8], red_out[23:16];
  // tlast = row_end; tuser = frame_end[0]
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [23:0]                         m_axis_tdata,
  output logic                                m_axis_tlast,
  output logic [0:0]                          m_axis_tuser,
  // configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bbd_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [bbd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [bbd_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);

  import bbd_pkg::*;

  localparam int NW = $clog2(OFIFO_DEPTH + 1);

  cfg_t          cfg;
  px_t           px;
  rgb_t          rgb, head;
  logic          accept, px_valid, rgb_valid, pop;
  logic [1:0]    win_pend;
  logic [NW-1:0] fifo_cnt;
  logic [NW:0]   outstanding;

  bbd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // reserve queue room for every pixel still in the pipeline
  assign outstanding   = (NW + 1)'(fifo_cnt) + (NW + 1)'(win_pend) + (NW + 1)'(rgb_valid);
  assign s_axis_tready = outstanding < (NW + 1)'(OFIFO_DEPTH);
  assign accept        = s_axis_tvalid && s_axis_tready;

  bbd_window #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .accept_i      (accept),
    .pix_i         (s_axis_tdata),
    .frame_start_i (s_axis_tuser[0]),
    .px_o          (px),
    .px_valid_o    (px_valid),
    .pend_o        (win_pend)
  );

  bbd_color u_color (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .px_i        (px),
    .px_valid_i  (px_valid),
    .rgb_o       (rgb),
    .rgb_valid_o (rgb_valid)
  );

  assign pop = m_axis_tvalid && m_axis_tready;

  bbd_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rgb_valid),
    .data_i  (rgb),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (fifo_cnt)
  );

  assign m_axis_tvalid = fifo_cnt != '0;
  assign m_axis_tdata  = {head.red, head.green, head.blue};
  assign m_axis_tlast  = head.row_end;
  assign m_axis_tuser  = head.frame_end;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rgb_valid |-> (fifo_cnt < NW'(OFIFO_DEPTH)) || pop)
    else $error("output queue overflow");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding <= (NW + 1)'(OFIFO_DEPTH))
    else $error("more pixels in flight than queue room");

  a_frame_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("frame end without row end");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/bbd_ram.sv -----
`default_nettype none

module bbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first: a read at the written address returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/bbd_cfg.sv -----
`default_nettype none

module bbd_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bbd_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [bbd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [bbd_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  output bbd_pkg::cfg_t                       cfg_o
);

  import bbd_pkg::*;

  cfg_t cfg_q, cfg_d;
  reg_e sel;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign sel    = reg_e'(paddr[PADDR_W-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        REG_LINE_WIDTH:   cfg_d.line_width    = pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: cfg_d.frame_height  = pwdata[CFG_W-1:0];
        REG_PATTERN:      cfg_d.bayer_pattern = pwdata[PAT_W-1:0];
        REG_BLUE_GAIN:    cfg_d.blue_gain     = pwdata[GAIN_W-1:0];
        REG_GREEN_GAIN:   cfg_d.green_gain    = pwdata[GAIN_W-1:0];
        REG_RED_GAIN:     cfg_d.red_gain      = pwdata[GAIN_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_LINE_WIDTH:   prdata = APB_DATA_W'(cfg_q.line_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(cfg_q.frame_height);
      REG_PATTERN:      prdata = APB_DATA_W'(cfg_q.bayer_pattern);
      REG_BLUE_GAIN:    prdata = APB_DATA_W'(cfg_q.blue_gain);
      REG_GREEN_GAIN:   prdata = APB_DATA_W'(cfg_q.green_gain);
      REG_RED_GAIN:     prdata = APB_DATA_W'(cfg_q.red_gain);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_width    <= RST_LINE_WIDTH;
      cfg_q.frame_height  <= RST_FRAME_HEIGHT;
      cfg_q.bayer_pattern <= RST_PATTERN;
      cfg_q.blue_gain     <= RST_GAIN;
      cfg_q.green_gain    <= RST_GAIN;
      cfg_q.red_gain      <= RST_GAIN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/core/bbd_window.sv -----
`default_nettype none

module bbd_window #(
  parameter int MAX_LINE_WIDTH = bbd_pkg::DEF_MAX_LINE_WIDTH
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire bbd_pkg::cfg_t             cfg_i,
  input  wire logic                      accept_i,
  input  wire logic [bbd_pkg::PIX_W-1:0] pix_i,
  input  wire logic                      frame_start_i,
  output bbd_pkg::px_t                   px_o,
  output logic                           px_valid_o,
  output logic [1:0]                     pend_o
);

  import bbd_pkg::*;

  localparam int CW = $clog2(MAX_LINE_WIDTH);
  localparam int EW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

  // position counters
  logic [CW-1:0]    col_q, col_d, col_cur;
  logic [ROW_W-1:0] row_q, row_d, row_cur;
  logic [EW-1:0]    w_eff, col_inc;
  logic [ROW_W:0]   row_inc;
  logic             last_col, last_row, has_result, green, blue_vert;

  // stage 1: line store data arrives
  logic             s1_valid_q, s1_res_q;
  logic [CW-1:0]    s1_col_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic             s1_green_q, s1_bvert_q, s1_row_end_q, s1_frame_end_q;
  logic             fwd_q;
  logic [2*PIX_W-1:0] fwd_data_q, ram_rdata, tm;
  logic [PIX_W-1:0] t_cur, m_cur;

  // window, left and middle columns
  logic [PIX_W-1:0] t0_q, m0_q, b0_q, t1_q, m1_q, b1_q;

  logic [SUM_W-1:0] two_tb, two_mm, four_corner, four_cross, copy_mid;
  chan_t            ch_a, ch_g, ch_b;
  px_t              px_d, px_q;
  logic             px_valid_q;

  assign w_eff = (EW'(cfg_i.line_width) > EW'(MAX_LINE_WIDTH)) ?
                 EW'(MAX_LINE_WIDTH) : EW'(cfg_i.line_width);

  assign col_cur    = frame_start_i ? '0 : col_q;
  assign row_cur    = frame_start_i ? '0 : row_q;
  assign col_inc    = EW'(col_cur) + EW'(1);
  assign row_inc    = {1'b0, row_cur} + (ROW_W + 1)'(1);
  assign last_col   = col_inc >= w_eff;
  assign last_row   = row_inc >= {1'b0, cfg_i.frame_height};
  assign has_result = (row_cur >= ROW_W'(2)) && (col_cur >= CW'(2));

  // color phase: columns flip it, rows flip it only for even widths
  assign green     = cfg_i.bayer_pattern[0] ^ (row_cur[0] & ~w_eff[0]) ^ col_cur[0];
  assign blue_vert = cfg_i.bayer_pattern[1] ^ row_cur[0];

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_d = col_inc[CW-1:0];
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line stores packed as {older, newer}; write back {newer, incoming}
  bbd_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i ({m_cur, s1_pix_q}),
    .re_i    (accept_i),
    .raddr_i (col_cur),
    .rdata_o (ram_rdata)
  );

  // forward the word being written when the next read hits the same column
  assign tm    = fwd_q ? fwd_data_q : ram_rdata;
  assign t_cur = tm[2*PIX_W-1:PIX_W];
  assign m_cur = tm[PIX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_res_q   <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
      s1_res_q   <= accept_i && has_result;
      fwd_q      <= accept_i && s1_valid_q && (col_cur == s1_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= {m_cur, s1_pix_q};
    if (accept_i) begin
      s1_col_q       <= col_cur;
      s1_pix_q       <= pix_i;
      s1_green_q     <= green;
      s1_bvert_q     <= blue_vert;
      s1_row_end_q   <= last_col;
      s1_frame_end_q <= last_col && last_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_q <= '0;
      m0_q <= '0;
      b0_q <= '0;
      t1_q <= '0;
      m1_q <= '0;
      b1_q <= '0;
    end else if (s1_valid_q) begin
      t0_q <= t1_q;
      m0_q <= m1_q;
      b0_q <= b1_q;
      t1_q <= t_cur;
      m1_q <= m_cur;
      b1_q <= s1_pix_q;
    end
  end

  assign two_tb      = SUM_W'(t1_q) + SUM_W'(b1_q);
  assign two_mm      = SUM_W'(m0_q) + SUM_W'(m_cur);
  assign four_corner = SUM_W'(t0_q) + SUM_W'(t_cur) + SUM_W'(b0_q) + SUM_W'(s1_pix_q);
  assign four_cross  = SUM_W'(t1_q) + SUM_W'(m0_q) + SUM_W'(m_cur) + SUM_W'(b1_q);
  assign copy_mid    = SUM_W'(m1_q);

  // ch_a: the non-green color on the vertical neighbors at a green center
  always_comb begin
    if (s1_green_q) begin
      ch_a = '{sum: two_tb,      mode: AVG_TWO};
      ch_g = '{sum: copy_mid,    mode: AVG_COPY};
      ch_b = '{sum: two_mm,      mode: AVG_TWO};
    end else begin
      ch_a = '{sum: four_corner, mode: AVG_FOUR};
      ch_g = '{sum: four_cross,  mode: AVG_FOUR};
      ch_b = '{sum: copy_mid,    mode: AVG_COPY};
    end
    px_d.blue      = s1_bvert_q ? ch_a : ch_b;
    px_d.green     = ch_g;
    px_d.red       = s1_bvert_q ? ch_b : ch_a;
    px_d.row_end   = s1_row_end_q;
    px_d.frame_end = s1_frame_end_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_valid_q <= 1'b0;
    end else begin
      px_valid_q <= s1_valid_q && s1_res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      px_q <= px_d;
    end
  end

  assign px_o       = px_q;
  assign px_valid_o = px_valid_q;
  assign pend_o     = {1'b0, s1_res_q} + {1'b0, px_valid_q};

endmodule

`default_nettype wire

// ----- rtl/core/bbd_color.sv -----
`default_nettype none

module bbd_color (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire bbd_pkg::cfg_t cfg_i,
  input  wire bbd_pkg::px_t  px_i,
  input  wire logic          px_valid_i,
  output bbd_pkg::rgb_t      rgb_o,
  output logic               rgb_valid_o
);

  import bbd_pkg::*;

  logic [PROD_W-1:0] prod_b_q, prod_g_q, prod_r_q;
  avg_e              mode_b_q, mode_g_q, mode_r_q;
  logic              row_end_q, frame_end_q, valid_q;

  // drop eight fraction bits, round by the neighbor count, clip at full scale
  function automatic logic [PIX_W-1:0] round_sat(input logic [PROD_W-1:0] prod,
                                                 input avg_e mode);
    logic [PROD_W-8:0] q;
    logic [PROD_W-8:0] v;
    q = {1'b0, prod[PROD_W-1:8]};
    case (mode)
      AVG_TWO:  v = (q + (PROD_W - 7)'(1)) >> 1;
      AVG_FOUR: v = (q + (PROD_W - 7)'(2)) >> 2;
      default:  v = q;
    endcase
    return (v > (PROD_W - 7)'(255)) ? {PIX_W{1'b1}} : v[PIX_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= px_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (px_valid_i) begin
      prod_b_q    <= PROD_W'(cfg_i.blue_gain) * PROD_W'(px_i.blue.sum);
      prod_g_q    <= PROD_W'(cfg_i.green_gain) * PROD_W'(px_i.green.sum);
      prod_r_q    <= PROD_W'(cfg_i.red_gain) * PROD_W'(px_i.red.sum);
      mode_b_q    <= px_i.blue.mode;
      mode_g_q    <= px_i.green.mode;
      mode_r_q    <= px_i.red.mode;
      row_end_q   <= px_i.row_end;
      frame_end_q <= px_i.frame_end;
    end
  end

  assign rgb_o.blue      = round_sat(prod_b_q, mode_b_q);
  assign rgb_o.green     = round_sat(prod_g_q, mode_g_q);
  assign rgb_o.red       = round_sat(prod_r_q, mode_r_q);
  assign rgb_o.row_end   = row_end_q;
  assign rgb_o.frame_end = frame_end_q;
  assign rgb_valid_o     = valid_q;

endmodule

`default_nettype wire

// ----- rtl/core/bbd_ofifo.sv -----
`default_nettype none

module bbd_ofifo (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       push_i,
  input  wire bbd_pkg::rgb_t                              data_i,
  input  wire logic                                       pop_i,
  output bbd_pkg::rgb_t                                   head_o,
  output logic [$clog2(bbd_pkg::OFIFO_DEPTH + 1)-1:0]     count_o
);

  import bbd_pkg::*;

  localparam int AW = $clog2(OFIFO_DEPTH);
  localparam int NW = $clog2(OFIFO_DEPTH + 1);

  rgb_t          mem_q [OFIFO_DEPTH];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= (wptr_q == AW'(OFIFO_DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(OFIFO_DEPTH - 1)) ? '0 : rptr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign head_o  = mem_q[rptr_q];
  assign count_o = cnt_q;

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import bbd_pkg::*;

  localparam int unsigned MAX_LW       = DEF_MAX_LINE_WIDTH;
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;
  logic [0:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;
  logic                  m_axis_tlast;
  logic [0:0]            m_axis_tuser;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [PADDR_W-1:0]    paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  bayer_bilinear_demosaic_wb u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Shadow registers
  bit [CFG_W-1:0]  cfg_width   = RST_LINE_WIDTH;
  bit [CFG_W-1:0]  cfg_height  = RST_FRAME_HEIGHT;
  bit [PAT_W-1:0]  cfg_pattern = RST_PATTERN;
  bit [GAIN_W-1:0] cfg_blue    = RST_GAIN;
  bit [GAIN_W-1:0] cfg_green   = RST_GAIN;
  bit [GAIN_W-1:0] cfg_red     = RST_GAIN;

  // Predictor state
  bit [7:0]    prev2_line [MAX_LW];
  bit [7:0]    prev1_line [MAX_LW];
  bit [7:0]    win_px [6];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;

  rgb_t        pending_rgb [$];
  int unsigned items_sent  = 0;
  int unsigned errors      = 0;
  bit          idle_on     = 1'b1;
  int unsigned hold_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  function automatic logic [7:0] wb_scale(int unsigned gain, int unsigned sum,
                                          int unsigned rnd, int unsigned sh);
    int unsigned v;
    v = (((gain * sum) >> 8) + rnd) >> sh;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // Advance the predictor by one raw sample and queue the pixel it yields
  function automatic void demosaic_pixel(logic [7:0] pix, logic sof);
    int unsigned w, h, col, row, ir, ic, ca, cb;
    int unsigned gain [3];
    logic [7:0]  res [3];
    bit [7:0]    t, m;
    bit          green, blue_vert;
    rgb_t        px;
    w = (cfg_width > MAX_LW) ? MAX_LW : cfg_width;
    h = cfg_height;
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    col = col_pos;
    row = row_pos;
    t = (col < MAX_LW) ? prev2_line[col] : 8'd0;
    m = (col < MAX_LW) ? prev1_line[col] : 8'd0;
    if (row >= 2 && col >= 2) begin
      ir = row - 2;
      ic = col - 2;
      gain[0] = cfg_blue;
      gain[1] = cfg_green;
      gain[2] = cfg_red;
      green = cfg_pattern[0] ^ ((((ir & (w - 1)) ^ ic) & 1) != 0);
      blue_vert = cfg_pattern[1] ^ ((ir & 1) != 0);
      ca = blue_vert ? 0 : 2;
      cb = 2 - ca;
      if (green) begin
        res[ca] = wb_scale(gain[ca], win_px[3] + win_px[5], 1, 1);
        res[1]  = wb_scale(gain[1], win_px[4], 0, 0);
        res[cb] = wb_scale(gain[cb], win_px[1] + m, 1, 1);
      end else begin
        res[ca] = wb_scale(gain[ca], win_px[0] + t + win_px[2] + pix, 2, 2);
        res[1]  = wb_scale(gain[1], win_px[3] + win_px[1] + m + win_px[5], 2, 2);
        res[cb] = wb_scale(gain[cb], win_px[4], 0, 0);
      end
      px.blue      = res[0];
      px.green     = res[1];
      px.red       = res[2];
      px.row_end   = (col + 1 >= w);
      px.frame_end = (col + 1 >= w) && (row + 1 >= h);
      pending_rgb.push_back(px);
    end
    win_px[0] = win_px[3];
    win_px[1] = win_px[4];
    win_px[2] = win_px[5];
    win_px[3] = t;
    win_px[4] = m;
    win_px[5] = pix;
    if (col < MAX_LW) begin
      prev2_line[col] = m;
      prev1_line[col] = pix;
    end
    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos = (row + 1 >= h) ? 0 : ((row + 1) & 12'hFFF);
    end else begin
      col_pos = col + 1;
    end
  endfunction

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int unsigned rand_gain();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 4095;
      2: return 256;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  task automatic set_reg(input reg_e idx, input logic [11:0] value);
    logic [APB_DATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_LINE_WIDTH:   cfg_width   = value;
      REG_FRAME_HEIGHT: cfg_height  = value;
      REG_PATTERN:      cfg_pattern = value[PAT_W-1:0];
      REG_BLUE_GAIN:    cfg_blue    = value;
      REG_GREEN_GAIN:   cfg_green   = value;
      REG_RED_GAIN:     cfg_red     = value;
      default: ;
    endcase
    // read it back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== APB_DATA_W'(value)) begin
      $error("prdata of %s mismatch: expected %0d, actual %0d", idx.name(), value, rd);
      errors++;
    end
  endtask

  task automatic write_config(input int unsigned w, input int unsigned h,
                              input int unsigned pat, input int unsigned bg,
                              input int unsigned gg, input int unsigned rg);
    set_reg(REG_LINE_WIDTH, 12'(w));
    set_reg(REG_FRAME_HEIGHT, 12'(h));
    set_reg(REG_PATTERN, 12'(pat));
    set_reg(REG_BLUE_GAIN, 12'(bg));
    set_reg(REG_GREEN_GAIN, 12'(gg));
    set_reg(REG_RED_GAIN, 12'(rg));
  endtask

  task automatic send_pixel(input logic [7:0] pix, input logic sof);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= sof;
    do @(posedge clk_i); while (!s_axis_tready);
    demosaic_pixel(pix, sof);
    items_sent++;
  endtask

  // stray_pct: chance in percent of a frame start on any sample not marked as the first
  task automatic send_frame(input int unsigned count, input bit mark_first,
                            input int unsigned stray_pct);
    bit sof;
    for (int unsigned i = 0; i < count; i++) begin
      sof = (i == 0 && mark_first) || ($urandom_range(0, 99) < stray_pct);
      send_pixel(rand_pixel(), sof);
    end
  endtask

  // Drop valid, collect every queued pixel, then let the pipeline empty
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned stall;
    rgb_t        want;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_cycles != 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (pending_rgb.size() == 0) begin
        $error("unexpected pixel: tdata %h, tlast %b, tuser %b",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        errors++;
      end else begin
        want = pending_rgb.pop_front();
        if (m_axis_tdata[7:0] !== want.blue) begin
          $error("blue_out mismatch: expected %0d, actual %0d", want.blue, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tdata[15:8] !== want.green) begin
          $error("green_out mismatch: expected %0d, actual %0d", want.green,
                 m_axis_tdata[15:8]);
          errors++;
        end
        if (m_axis_tdata[23:16] !== want.red) begin
          $error("red_out mismatch: expected %0d, actual %0d", want.red, m_axis_tdata[23:16]);
          errors++;
        end
        if (m_axis_tlast !== want.row_end) begin
          $error("row_end mismatch: expected %0d, actual %0d", want.row_end, m_axis_tlast);
          errors++;
        end
        if (m_axis_tuser[0] !== want.frame_end) begin
          $error("frame_end mismatch: expected %0d, actual %0d", want.frame_end,
                 m_axis_tuser[0]);
          errors++;
        end
      end
    end
  end

  // Pattern and gains left at their reset values
  task automatic test_reset_defaults();
    set_reg(REG_LINE_WIDTH, 12'd8);
    set_reg(REG_FRAME_HEIGHT, 12'd4);
    send_frame(8 * 4, 1'b1, 0);
  endtask

  task automatic test_extreme_pixels();
    wait_idle();
    write_config(4, 3, 0, 4095, 4095, 4095);
    for (int unsigned i = 0; i < 12; i++) send_pixel(8'd255, i == 0);
    wait_idle();
    write_config(4, 3, 3, 0, 4095, 128);
    for (int unsigned i = 0; i < 12; i++) send_pixel((i % 2) ? 8'd255 : 8'd0, i == 0);
  endtask

  // Odd width, frames running on without a frame start, restart mid-frame
  task automatic test_counter_wrap();
    wait_idle();
    write_config(5, 4, 1, 256, 300, 200);
    send_frame(20, 1'b1, 0);
    send_frame(20, 1'b0, 0);
    send_frame(7, 1'b1, 0);
    send_frame(20, 1'b1, 0);
    send_frame(13, 1'b0, 0);
  endtask

  task automatic test_tiny_frames();
    int unsigned tiny_w [7] = '{0, 1, 2, 6, 6, 6, 3};
    int unsigned tiny_h [7] = '{5, 5, 5, 0, 1, 2, 3};
    for (int i = 0; i < 7; i++) begin
      wait_idle();
      write_config(tiny_w[i], tiny_h[i], $urandom_range(0, 3), rand_gain(), rand_gain(),
                   rand_gain());
      send_frame(15, 1'b1, 0);
    end
  endtask

  // Width register beyond the line store size
  task automatic test_wide_line();
    wait_idle();
    idle_on = 1'b0;
    write_config(4095, 3, 2, rand_gain(), rand_gain(), rand_gain());
    send_frame(64, 1'b1, 0);
    wait_idle();
    idle_on = 1'b1;
  endtask

  task automatic test_tall_frame();
    wait_idle();
    idle_on = 1'b0;
    write_config(4, 4095, 1, 256, 256, 256);
    send_frame(4 * 8, 1'b1, 0);
    wait_idle();
    idle_on = 1'b1;
  endtask

  // Hold the receiver off long enough for the output queue to fill
  task automatic test_backpressure();
    wait_idle();
    write_config(16, 6, 2, 256, 256, 256);
    idle_on = 1'b0;
    hold_cycles = 300;
    send_frame(16 * 6, 1'b1, 0);
    wait_idle();
    idle_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int unsigned start, w, h, frames, kind;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      wait_idle();
      idle_on = ($urandom_range(0, 4) != 0);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(3, 16);
      h = $urandom_range(3, 8);
      write_config(w, h, $urandom_range(0, 3), rand_gain(), rand_gain(), rand_gain());
      frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++) begin
        kind = $urandom_range(0, 9);
        if (f == 0 || kind < 7) begin
          send_frame(w * h, 1'b1, 0);
        end else if (kind == 7) begin
          send_frame(w * h, 1'b0, 0);
        end else if (kind == 8) begin
          send_frame($urandom_range(1, w * h - 1), 1'b1, 0);
        end else begin
          send_frame(w * h, 1'b1, 5);
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_extreme_pixels();
    test_counter_wrap();
    test_tiny_frames();
    test_wide_line();
    test_tall_frame();
    test_backpressure();
    test_random_frames();
    wait_idle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
